// ===== sv/lzsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzsrd_pkg
// Shared types and constants of the LZSS ring decompressor.
// ----------------------------------------------------------------------------
package lzsrd_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int RING_AW = $clog2(RING_DEPTH);
	localparam logic [RING_AW-1:0] START_POS = RING_AW'(12'hFEE);

	localparam logic [31:0] MAX_LEN = 32'd8000000;
	localparam int DECL_W = 23;
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] LEN_BIAS = CNT_W'(3);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_TOKEN,
		PH_MATCH2
	} phase_t;

	typedef enum logic [1:0] {
		K_LIT,
		K_MATCH,
		K_ERR
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         data;
		logic [RING_AW-1:0] off;
		logic [CNT_W-1:0]   cnt;
		logic               fend;
		logic               restart;
		logic [DECL_W-1:0]  decl;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== sv/lzsrd_front.sv =====
// ----------------------------------------------------------------------------
// lzsrd_front
// Parses the compressed stream: header, control bytes and tokens, and queues
// one command per literal, match or size error.
// ----------------------------------------------------------------------------
module lzsrd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    src_valid,
	output logic                    src_stall,
	input  logic [7:0]              in_byte,
	input  logic                    first_of_file,
	input  lzsrd_pkg::q_stat_t      q_stat,
	input  logic                    clearing,
	output logic                    push,
	output lzsrd_pkg::cmd_t         cmd
);

	lzsrd_pkg::phase_t phase_q, phase_d;
	logic [1:0] hdr_q, hdr_d;
	logic [31:0] acc_q, acc_d, acc_new;
	logic [8:0] flags_q, flags_d;
	logic [lzsrd_pkg::DECL_W-1:0] left_q, left_d;
	logic [lzsrd_pkg::DECL_W-1:0] decl_q, decl_d;
	logic [7:0] offlo_q, offlo_d;
	logic restart_q, restart_d;
	logic [lzsrd_pkg::CNT_W-1:0] mlen;
	logic accept;

	assign src_stall = q_stat.full | clearing;
	assign accept = src_valid & ~src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lzsrd_pkg::PH_IDLE;
			hdr_q <= '0;
			acc_q <= '0;
			flags_q <= 9'd1;
			left_q <= '0;
			decl_q <= '0;
			offlo_q <= '0;
			restart_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			hdr_q <= hdr_d;
			acc_q <= acc_d;
			flags_q <= flags_d;
			left_q <= left_d;
			decl_q <= decl_d;
			offlo_q <= offlo_d;
			restart_q <= restart_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		hdr_d = hdr_q;
		acc_d = acc_q;
		flags_d = flags_q;
		left_d = left_q;
		decl_d = decl_q;
		offlo_d = offlo_q;
		restart_d = restart_q;
		push = 1'b0;
		acc_new = acc_q | ({24'd0, in_byte} << {hdr_q, 3'b000});
		mlen = {1'b0, in_byte[3:0]} + lzsrd_pkg::LEN_BIAS;
		cmd.kind = lzsrd_pkg::K_LIT;
		cmd.data = in_byte;
		cmd.off = {in_byte[7:4], offlo_q};
		cmd.cnt = lzsrd_pkg::CNT_W'(1);
		cmd.fend = 1'b0;
		cmd.restart = restart_q;
		cmd.decl = decl_q;
		if (accept) begin
			if (first_of_file) begin
				phase_d = lzsrd_pkg::PH_HEADER;
				hdr_d = 2'd1;
				acc_d = {24'd0, in_byte};
				flags_d = 9'd1;
				left_d = '0;
				restart_d = 1'b1;
			end else begin
				unique case (phase_q)
					lzsrd_pkg::PH_HEADER: begin
						acc_d = acc_new;
						hdr_d = hdr_q + 2'd1;
						if (hdr_q == 2'd3) begin
							if (acc_new > lzsrd_pkg::MAX_LEN) begin
								push = 1'b1;
								cmd.kind = lzsrd_pkg::K_ERR;
								cmd.decl = lzsrd_pkg::MAX_LEN[lzsrd_pkg::DECL_W-1:0];
								decl_d = lzsrd_pkg::MAX_LEN[lzsrd_pkg::DECL_W-1:0];
								phase_d = lzsrd_pkg::PH_IDLE;
							end else if (acc_new == 32'd0) begin
								phase_d = lzsrd_pkg::PH_IDLE;
							end else begin
								left_d = acc_new[lzsrd_pkg::DECL_W-1:0];
								decl_d = acc_new[lzsrd_pkg::DECL_W-1:0];
								phase_d = lzsrd_pkg::PH_TOKEN;
							end
						end
					end
					lzsrd_pkg::PH_TOKEN: begin
						if (flags_q[8:1] == 8'd0) begin
							flags_d = {1'b1, in_byte};
						end else if (flags_q[0]) begin
							push = 1'b1;
							cmd.fend = (left_q == lzsrd_pkg::DECL_W'(1));
							left_d = left_q - lzsrd_pkg::DECL_W'(1);
							flags_d = flags_q >> 1;
							if (left_q == lzsrd_pkg::DECL_W'(1)) begin
								phase_d = lzsrd_pkg::PH_IDLE;
							end
						end else begin
							offlo_d = in_byte;
							phase_d = lzsrd_pkg::PH_MATCH2;
						end
					end
					lzsrd_pkg::PH_MATCH2: begin
						push = 1'b1;
						cmd.kind = lzsrd_pkg::K_MATCH;
						flags_d = flags_q >> 1;
						if (lzsrd_pkg::DECL_W'(mlen) >= left_q) begin
							cmd.cnt = left_q[lzsrd_pkg::CNT_W-1:0];
							cmd.fend = 1'b1;
							left_d = '0;
							phase_d = lzsrd_pkg::PH_IDLE;
						end else begin
							cmd.cnt = mlen;
							left_d = left_q - lzsrd_pkg::DECL_W'(mlen);
							phase_d = lzsrd_pkg::PH_TOKEN;
						end
					end
					default: begin
					end
				endcase
				if (push) begin
					restart_d = 1'b0;
				end
			end
		end
	end

endmodule

// ===== sv/lzsrd_fifo.sv =====
// ----------------------------------------------------------------------------
// lzsrd_fifo
// Short command queue between the stream parser and the copy engine.
// ----------------------------------------------------------------------------
module lzsrd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lzsrd_pkg::cmd_t     wr_cmd,
	input  logic                pop,
	output lzsrd_pkg::cmd_t     rd_cmd,
	output lzsrd_pkg::q_stat_t  stat
);

	lzsrd_pkg::cmd_t slot_q [lzsrd_pkg::FIFO_DEPTH];
	logic [lzsrd_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [lzsrd_pkg::FIFO_AW:0] count_q;
	logic do_push, do_pop;

	assign stat.full = (count_q == (lzsrd_pkg::FIFO_AW + 1)'(lzsrd_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push = push & ~stat.full;
	assign do_pop = pop & ~stat.empty;
	assign rd_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/lzsrd_back.sv =====
// ----------------------------------------------------------------------------
// lzsrd_back
// Copy engine: owns the history ring, expands commands into output bytes and
// holds the output register. Clears the ring after reset.
// ----------------------------------------------------------------------------
module lzsrd_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lzsrd_pkg::cmd_t                   q_cmd,
	input  lzsrd_pkg::q_stat_t                q_stat,
	output logic                              pop,
	output logic                              clearing,
	output logic                              dst_valid,
	input  logic                              dst_stall,
	output logic [7:0]                        out_byte,
	output logic                              run_end,
	output logic                              file_end,
	output logic                              size_error,
	output logic [lzsrd_pkg::DECL_W-1:0]      declared_length
);

	logic [7:0] ring [lzsrd_pkg::RING_DEPTH];

	logic clr_q;
	logic [lzsrd_pkg::RING_AW-1:0] clr_addr_q;
	logic [lzsrd_pkg::RING_AW-1:0] wp_q;

	lzsrd_pkg::kind_t kind_q;
	logic [7:0] lit_q;
	logic [lzsrd_pkg::RING_AW-1:0] off_q;
	logic [lzsrd_pkg::CNT_W-1:0] cnt_q;
	logic fend_q, restart_q;
	logic [lzsrd_pkg::DECL_W-1:0] decl_q;

	logic vld_s1, mem_s1, wr_s1, restart_s1, run_end_s1, fend_s1, err_s1;
	logic [7:0] data_s1;
	logic [lzsrd_pkg::DECL_W-1:0] decl_s1;
	logic [7:0] rd_q;

	logic out_vld_q, run_end_q, file_end_q, size_error_q;
	logic [7:0] out_byte_q;
	logic [lzsrd_pkg::DECL_W-1:0] decl_out_q;

	logic adv, move, issue, byp, rd_en, we, last;
	logic [7:0] s1_data, wdata;
	logic [lzsrd_pkg::RING_AW-1:0] weff, waddr;

	assign adv = ~out_vld_q | ~dst_stall;
	assign move = vld_s1 & adv;
	assign issue = (cnt_q != '0) & (~vld_s1 | adv);
	assign pop = ~clr_q & (cnt_q == '0) & ~q_stat.empty;
	assign last = (cnt_q == lzsrd_pkg::CNT_W'(1));
	assign s1_data = mem_s1 ? rd_q : data_s1;
	assign weff = restart_s1 ? lzsrd_pkg::START_POS : wp_q;
	assign byp = move & wr_s1 & (weff == off_q);
	assign rd_en = issue & (kind_q == lzsrd_pkg::K_MATCH);
	assign we = clr_q | (move & wr_s1);
	assign waddr = clr_q ? clr_addr_q : weff;
	assign wdata = clr_q ? 8'd0 : s1_data;
	assign clearing = clr_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ring[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= ring[off_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
			wp_q <= lzsrd_pkg::START_POS;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == lzsrd_pkg::RING_AW'(lzsrd_pkg::RING_DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (move) begin
				wp_q <= wr_s1 ? weff + 1'b1 : weff;
			end
			if (pop) begin
				cnt_q <= q_cmd.cnt;
			end else if (issue) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (issue) begin
				vld_s1 <= 1'b1;
			end else if (move) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= q_cmd.kind;
			lit_q <= q_cmd.data;
			off_q <= q_cmd.off;
			fend_q <= q_cmd.fend;
			restart_q <= q_cmd.restart;
			decl_q <= q_cmd.decl;
		end else if (issue) begin
			off_q <= off_q + 1'b1;
			restart_q <= 1'b0;
		end
		if (issue) begin
			restart_s1 <= restart_q;
			run_end_s1 <= last;
			decl_s1 <= decl_q;
			unique case (kind_q)
				lzsrd_pkg::K_LIT: begin
					data_s1 <= lit_q;
					mem_s1 <= 1'b0;
					wr_s1 <= 1'b1;
					err_s1 <= 1'b0;
					fend_s1 <= fend_q & last;
				end
				lzsrd_pkg::K_MATCH: begin
					data_s1 <= byp ? s1_data : 8'd0;
					mem_s1 <= ~byp;
					wr_s1 <= 1'b1;
					err_s1 <= 1'b0;
					fend_s1 <= fend_q & last;
				end
				default: begin
					data_s1 <= 8'd0;
					mem_s1 <= 1'b0;
					wr_s1 <= 1'b0;
					err_s1 <= 1'b1;
					fend_s1 <= 1'b0;
				end
			endcase
		end
		if (move) begin
			out_byte_q <= s1_data;
			run_end_q <= run_end_s1;
			file_end_q <= fend_s1;
			size_error_q <= err_s1;
			decl_out_q <= decl_s1;
		end
	end

	assign dst_valid = out_vld_q;
	assign out_byte = out_byte_q;
	assign run_end = run_end_q;
	assign file_end = file_end_q;
	assign size_error = size_error_q;
	assign declared_length = decl_out_q;

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !issue && !dst_valid)
		else $error("Copy activity during the ring clearing pass.");

	a_end_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && file_end_q |-> run_end_q)
		else $error("File end without run end.");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && size_error_q |-> run_end_q && !file_end_q && out_byte_q == 8'd0)
		else $error("Malformed size error result.");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(data_s1) && $stable(mem_s1))
		else $error("Read stage lost its entry while the output stalled.");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q == '0 && !issue)
		else $error("Command loaded while a copy was in progress.");

endmodule

// ===== sv/lzss_ring_decompressor_top.sv =====
// ----------------------------------------------------------------------------
// lzss_ring_decompressor_top
// LZSS decompressor with a 4096-byte history ring.
//
// The source channel (src_valid, src_stall, in_byte, first_of_file) takes
// one compressed byte per transaction; first_of_file marks the first of the
// four little-endian length bytes of a file. The destination channel
// (dst_valid, dst_stall and the result fields) gives one decompressed byte
// per transaction, or a single size_error transaction for an oversized
// header.
// In the copy engine each command is loaded from the queue; then each of its
// bytes (one for a literal, up to 18 for a match) goes through the read stage
// into the output register. The ring has one write and one read port, which
// sets one byte per cycle while a match is copied and the output does not stall.
// A four-entry command queue lets the parser keep taking bytes while the
// copy engine runs or the receiver stalls; src_stall rises when it is full.
// While dst_stall is high and dst_valid is set, the output register holds and
// the copy pauses. After reset the ring is cleared to zero while src_stall is high.
// ----------------------------------------------------------------------------
module lzss_ring_decompressor_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             src_valid,
	output logic                             src_stall,
	input  logic [7:0]                       in_byte,
	input  logic                             first_of_file,
	output logic                             dst_valid,
	input  logic                             dst_stall,
	output logic [7:0]                       out_byte,
	output logic                             run_end,
	output logic                             file_end,
	output logic                             size_error,
	output logic [lzsrd_pkg::DECL_W-1:0]     declared_length
);

	lzsrd_pkg::cmd_t push_cmd, head_cmd;
	lzsrd_pkg::q_stat_t q_stat;
	logic push, pop, clearing;

	lzsrd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.src_valid     (src_valid),
		.src_stall     (src_stall),
		.in_byte       (in_byte),
		.first_of_file (first_of_file),
		.q_stat        (q_stat),
		.clearing      (clearing),
		.push          (push),
		.cmd           (push_cmd)
	);

	lzsrd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (push_cmd),
		.pop    (pop),
		.rd_cmd (head_cmd),
		.stat   (q_stat)
	);

	lzsrd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_cmd           (head_cmd),
		.q_stat          (q_stat),
		.pop             (pop),
		.clearing        (clearing),
		.dst_valid       (dst_valid),
		.dst_stall       (dst_stall),
		.out_byte        (out_byte),
		.run_end         (run_end),
		.file_end        (file_end),
		.size_error      (size_error),
		.declared_length (declared_length)
	);

endmodule

// ===== tb/lzsrd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzsrd_checker
// Watches both channels of the LZSS ring decompressor. Every accepted input
// transaction is decoded by a local model of the decompressor with its own
// history ring, and the bytes it produces are queued in order. Every accepted
// output transaction is compared field by field with the oldest queued byte.
// ----------------------------------------------------------------------------
module lzsrd_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         src_valid,
	input  logic                         src_stall,
	input  logic [7:0]                   in_byte,
	input  logic                         first_of_file,
	input  logic                         dst_valid,
	input  logic                         dst_stall,
	input  logic [7:0]                   out_byte,
	input  logic                         run_end,
	input  logic                         file_end,
	input  logic                         size_error,
	input  logic [lzsrd_pkg::DECL_W-1:0] declared_length,
	output int                           fail_count,
	output int                           pending_count
);

	typedef struct packed {
		logic [7:0]                   data;
		logic                         run_end;
		logic                         file_end;
		logic                         size_error;
		logic [lzsrd_pkg::DECL_W-1:0] decl;
	} byte_result_t;

	byte_result_t predicted_bytes[$];
	byte_result_t head;

	logic [7:0]                    ring [lzsrd_pkg::RING_DEPTH];
	logic [lzsrd_pkg::RING_AW-1:0] wr_pos;
	logic [8:0]                    flags;
	logic [lzsrd_pkg::DECL_W-1:0]  left;
	logic [2:0]                    hdr_cnt;
	logic [31:0]                   len_acc;
	logic [7:0]                    off_lo;
	lzsrd_pkg::phase_t             phase;

	function automatic logic [lzsrd_pkg::DECL_W-1:0] saturated_length();
		return (len_acc > lzsrd_pkg::MAX_LEN) ? lzsrd_pkg::DECL_W'(lzsrd_pkg::MAX_LEN)
			: lzsrd_pkg::DECL_W'(len_acc);
	endfunction

	function automatic void emit_byte(input logic [7:0] v);
		byte_result_t r;
		ring[wr_pos] = v;
		wr_pos = wr_pos + 1'b1;
		if (left != 0)
			left = left - 1'b1;
		r.data = v;
		r.run_end = 1'b0;
		r.file_end = (left == 0);
		r.size_error = 1'b0;
		r.decl = saturated_length();
		predicted_bytes.push_back(r);
		if (left == 0)
			phase = lzsrd_pkg::PH_IDLE;
	endfunction

	function automatic void decompress_step(input logic [7:0] b, input logic first);
		byte_result_t r;
		int start_count;
		int copy_len;
		logic [lzsrd_pkg::RING_AW-1:0] src_pos;
		start_count = predicted_bytes.size();
		if (first) begin
			wr_pos = lzsrd_pkg::START_POS;
			flags = 9'h001;
			left = '0;
			len_acc = {24'd0, b};
			hdr_cnt = 3'd1;
			phase = lzsrd_pkg::PH_HEADER;
			return;
		end
		case (phase)
			lzsrd_pkg::PH_HEADER: begin
				len_acc = len_acc | ({24'd0, b} << {hdr_cnt[1:0], 3'b000});
				hdr_cnt = hdr_cnt + 3'd1;
				if (hdr_cnt >= 3'd4) begin
					hdr_cnt = '0;
					if (len_acc > lzsrd_pkg::MAX_LEN) begin
						r.data = 8'h00;
						r.run_end = 1'b0;
						r.file_end = 1'b0;
						r.size_error = 1'b1;
						r.decl = saturated_length();
						predicted_bytes.push_back(r);
						phase = lzsrd_pkg::PH_IDLE;
					end else if (len_acc == 0) begin
						phase = lzsrd_pkg::PH_IDLE;
					end else begin
						left = lzsrd_pkg::DECL_W'(len_acc);
						phase = lzsrd_pkg::PH_TOKEN;
					end
				end
			end
			lzsrd_pkg::PH_TOKEN: begin
				if (flags <= 9'd1) begin
					flags = {1'b1, b};
				end else if (flags[0]) begin
					emit_byte(b);
					flags = flags >> 1;
				end else begin
					off_lo = b;
					phase = lzsrd_pkg::PH_MATCH2;
				end
			end
			lzsrd_pkg::PH_MATCH2: begin
				copy_len = int'(b[3:0]) + 3;
				src_pos = {b[7:4], off_lo};
				phase = lzsrd_pkg::PH_TOKEN;
				flags = flags >> 1;
				// The copy reads the ring byte by byte, so an overlapping copy repeats data.
				while (copy_len > 0 && left != 0) begin
					emit_byte(ring[src_pos]);
					src_pos = src_pos + 1'b1;
					copy_len--;
				end
			end
			default: begin
			end
		endcase
		if (predicted_bytes.size() > start_count) begin
			r = predicted_bytes.pop_back();
			r.run_end = 1'b1;
			predicted_bytes.push_back(r);
		end
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (ring[i])
				ring[i] = 8'h00;
			wr_pos = lzsrd_pkg::START_POS;
			flags = 9'h001;
			left = '0;
			hdr_cnt = '0;
			len_acc = '0;
			off_lo = '0;
			phase = lzsrd_pkg::PH_IDLE;
			predicted_bytes.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (src_valid === 1'b1 && src_stall === 1'b0)
				decompress_step(in_byte, first_of_file);
			if (dst_valid === 1'b1 && dst_stall === 1'b0) begin
				if (predicted_bytes.size() == 0) begin
					$error("out_byte: expected no transaction, actual %0h", out_byte);
					fail_count++;
				end else begin
					head = predicted_bytes.pop_front();
					compare_field("out_byte", 32'(head.data), 32'(out_byte));
					compare_field("run_end", 32'(head.run_end), 32'(run_end));
					compare_field("file_end", 32'(head.file_end), 32'(file_end));
					compare_field("size_error", 32'(head.size_error), 32'(size_error));
					compare_field("declared_length", 32'(head.decl), 32'(declared_length));
				end
			end
			pending_count = predicted_bytes.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the LZSS ring decompressor. A directed set of files covers
// oversized and empty headers, the largest legal length, a file restarted in
// the middle of a match, an overlapping match cut at the end of a file and
// bytes sent while idle. Random files follow, most of them well formed, with
// random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_ITEMS = 80;
	localparam int LONG_HOLD = 400;
	localparam int TAIL_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
	} src_item_t;

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         src_valid = 1'b0;
	logic                         src_stall;
	logic [7:0]                   in_byte = 8'h00;
	logic                         first_of_file = 1'b0;
	logic                         dst_valid;
	logic                         dst_stall = 1'b0;
	logic [7:0]                   out_byte;
	logic                         run_end;
	logic                         file_end;
	logic                         size_error;
	logic [lzsrd_pkg::DECL_W-1:0] declared_length;
	int                           fail_count;
	int                           pending_count;
	logic                         hold_req = 1'b0;
	int unsigned                  cycle_count = 0;
	src_item_t                    stream_q[$];

	lzss_ring_decompressor_top u_top (.*);

	lzsrd_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	function automatic int next_gap(ref int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(10, 40);
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic first);
		src_item_t it;
		it.data = b;
		it.first = first;
		stream_q.push_back(it);
	endfunction

	function automatic void push_len(input logic [31:0] len);
		push_byte(len[7:0], 1'b1);
		push_byte(len[15:8], 1'b0);
		push_byte(len[23:16], 1'b0);
		push_byte(len[31:24], 1'b0);
	endfunction

	function automatic void add_file(input int unsigned len, input logic truncate);
		int unsigned made;
		int unsigned stop_at;
		int k;
		logic [7:0] ctrl;
		logic [3:0] nib;
		logic [lzsrd_pkg::RING_AW-1:0] pos;
		logic [lzsrd_pkg::RING_AW-1:0] off;
		push_len(len);
		made = 0;
		pos = lzsrd_pkg::START_POS;
		stop_at = truncate ? $urandom_range(1, len - 1) : len;
		while (made < stop_at) begin
			ctrl = 8'($urandom);
			push_byte(ctrl, 1'b0);
			for (k = 0; k < 8 && made < stop_at; k++) begin
				if (ctrl[k]) begin
					push_byte(8'($urandom), 1'b0);
					made++;
				end else begin
					nib = 4'($urandom);
					// Most matches point just behind the write position to reuse fresh data.
					if ($urandom_range(0, 3) != 0)
						off = pos - lzsrd_pkg::RING_AW'($urandom_range(1, 18));
					else
						off = lzsrd_pkg::RING_AW'($urandom);
					push_byte(off[7:0], 1'b0);
					push_byte({off[11:8], nib}, 1'b0);
					made += int'(nib) + 3;
				end
				pos = lzsrd_pkg::START_POS + lzsrd_pkg::RING_AW'(made);
			end
		end
		if (truncate && $urandom_range(0, 1) == 1)
			push_byte(8'($urandom), 1'b0);
	endfunction

	initial begin
		int calm;
		int stall_left;
		logic hold_done;
		calm = 0;
		stall_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				stall_left = LONG_HOLD;
			end else if (stall_left > 0) begin
				stall_left--;
			end else begin
				stall_left = next_gap(calm);
			end
			dst_stall <= (stall_left > 0);
		end
	end

	initial begin
		int calm;
		int gap;
		int n_directed;
		int pick;
		calm = 0;

		push_byte(8'h5A, 1'b0);
		push_len(32'hFFFF_FFFF);
		push_len(32'd0);
		push_len(lzsrd_pkg::MAX_LEN);
		push_byte(8'h02, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h10, 1'b0);
		push_len(32'd5);
		push_byte(8'h01, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hEE, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h33, 1'b0);
		n_directed = stream_q.size();

		while (stream_q.size() < n_directed + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				add_file($urandom_range(1, 40), 1'b0);
			else if (pick < 72)
				add_file($urandom_range(41, 150), 1'b0);
			else if (pick < 84)
				add_file($urandom_range(5, 120), 1'b1);
			else if (pick < 90)
				push_len($urandom_range(lzsrd_pkg::MAX_LEN + 1, 32'hFFFF_FFFF));
			else if (pick < 94)
				push_len(32'd0);
			else
				push_byte(8'($urandom), 1'b0);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stream_q[i]) begin
			if (i == n_directed)
				hold_req <= 1'b1;
			gap = next_gap(calm);
			if (gap > 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			src_valid <= 1'b1;
			in_byte <= stream_q[i].data;
			first_of_file <= stream_q[i].first;
			do
				@(posedge clk);
			while (src_stall);
		end
		src_valid <= 1'b0;

		@(posedge clk);
		wait (pending_count == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
